// ===== rtl/core/rfsh_pkg.sv =====
`default_nettype none

package rfsh_pkg;

  // Frame and response byte values.
  localparam logic [7:0] STX_BYTE   = 8'h02;
  localparam logic [7:0] CMD_WRITE  = 8'h37;
  localparam logic [7:0] CMD_READ   = 8'h38;
  localparam logic [7:0] ACK_BYTE   = 8'h06;
  localparam logic [7:0] READ_COUNT = 8'h01;
  localparam logic [7:0] WR1_COUNT  = 8'h01;
  localparam logic [7:0] WR2_COUNT  = 8'h02;

  // Receive count limits; the count holds bytes taken before the current one.
  localparam logic [6:0] COUNT_MAX   = 7'd127;
  localparam logic [6:0] CNT_THIRD   = 7'd2;
  localparam logic [6:0] CNT_ACK_LEN = 7'd3;

  // Frame byte positions.
  localparam logic [2:0] IDX_STX   = 3'd0;
  localparam logic [2:0] IDX_CMD   = 3'd1;
  localparam logic [2:0] IDX_ADDR  = 3'd2;
  localparam logic [2:0] IDX_COUNT = 3'd3;
  localparam logic [2:0] IDX_DLO   = 3'd4;
  localparam logic [2:0] IDX_DHI   = 3'd5;
  localparam logic [2:0] LAST_WR1  = 3'd5;
  localparam logic [2:0] LAST_WR2  = 3'd6;
  localparam logic [2:0] LAST_RD   = 3'd4;

  typedef enum logic [1:0] {
    ACT_WR1 = 2'd0,
    ACT_WR2 = 2'd1,
    ACT_RD  = 2'd2,
    ACT_RX  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    PEND_NONE  = 2'd0,
    PEND_WRITE = 2'd1,
    PEND_READ  = 2'd2
  } pending_t;

  typedef enum logic [1:0] {
    VD_OK   = 2'd0,
    VD_CSUM = 2'd1,
    VD_NACK = 2'd2,
    VD_LEN  = 2'd3
  } verdict_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  reg_addr;
    logic [15:0] write_value;
    logic [7:0]  rx_byte;
    logic        rx_last;
  } in_t;

  typedef struct packed {
    logic       out_kind;
    logic [7:0] tx_byte;
    logic       last_of_run;
    logic [1:0] verdict;
    logic [7:0] read_value;
  } out_t;

  // One unit of work passed from the front to the back.
  typedef struct packed {
    logic        is_verdict;
    action_t     action;
    logic [7:0]  addr;
    logic [15:0] wval;
    verdict_t    verdict;
    logic [7:0]  rv;
  } job_t;

endpackage

`default_nettype wire

// ===== rtl/core/rfsh_front.sv =====
`default_nettype none

module rfsh_front #(
  parameter int MAX_RESPONSE_BYTES = 64
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          accept,
  input  wire rfsh_pkg::in_t item,
  output logic               push,
  output rfsh_pkg::job_t     job
);

  localparam logic [7:0] MAX_BYTES = 8'(MAX_RESPONSE_BYTES);

  rfsh_pkg::pending_t pending;
  logic [6:0]         rx_count;
  logic [7:0]         rx_sum;
  logic [7:0]         third_byte;
  logic               rx_overflow;

  rfsh_pkg::action_t  act;
  logic               ovf_eff;
  logic [7:0]         third_eff;
  rfsh_pkg::verdict_t vd;

  assign act = rfsh_pkg::action_t'(item.action);

  // The current byte counts toward overflow and may itself be the third byte.
  assign ovf_eff   = rx_overflow || ({1'b0, rx_count} >= MAX_BYTES);
  assign third_eff = (rx_count == rfsh_pkg::CNT_THIRD) ? item.rx_byte : third_byte;

  // Verdict for a closing response byte, in priority order.
  always_comb begin
    if (pending == rfsh_pkg::PEND_NONE) begin
      vd = rfsh_pkg::VD_NACK;
    end else if (rx_count < rfsh_pkg::CNT_THIRD || ovf_eff) begin
      vd = rfsh_pkg::VD_LEN;
    end else if (rx_sum != item.rx_byte) begin
      vd = rfsh_pkg::VD_CSUM;
    end else if (pending == rfsh_pkg::PEND_WRITE &&
                 (rx_count != rfsh_pkg::CNT_ACK_LEN || third_eff != rfsh_pkg::ACK_BYTE)) begin
      vd = rfsh_pkg::VD_NACK;
    end else begin
      vd = rfsh_pkg::VD_OK;
    end
  end

  // Classify the item into a job for the back end.
  always_comb begin
    push           = accept && (act != rfsh_pkg::ACT_RX || item.rx_last);
    job.is_verdict = (act == rfsh_pkg::ACT_RX);
    job.action     = act;
    job.addr       = item.reg_addr;
    job.wval       = item.write_value;
    job.verdict    = vd;
    job.rv         = (rx_count >= rfsh_pkg::CNT_THIRD) ? third_eff : 8'h00;
  end

  // Pending request and receive state.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending     <= rfsh_pkg::PEND_NONE;
      rx_count    <= '0;
      rx_sum      <= '0;
      third_byte  <= '0;
      rx_overflow <= 1'b0;
    end else if (accept) begin
      if (act != rfsh_pkg::ACT_RX || item.rx_last) begin
        if (act == rfsh_pkg::ACT_RX) begin
          pending <= rfsh_pkg::PEND_NONE;
        end else if (act == rfsh_pkg::ACT_RD) begin
          pending <= rfsh_pkg::PEND_READ;
        end else begin
          pending <= rfsh_pkg::PEND_WRITE;
        end
        rx_count    <= '0;
        rx_sum      <= '0;
        third_byte  <= '0;
        rx_overflow <= 1'b0;
      end else begin
        rx_overflow <= ovf_eff;
        third_byte  <= third_eff;
        rx_sum      <= rx_sum + item.rx_byte;
        if (rx_count < rfsh_pkg::COUNT_MAX) begin
          rx_count <= rx_count + 7'd1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/rfsh_queue.sv =====
`default_nettype none

module rfsh_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire rfsh_pkg::job_t push_job,
  input  wire logic           pop,
  output rfsh_pkg::job_t      head,
  output logic                full,
  output logic                empty
);

  rfsh_pkg::job_t entries [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = entries[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/rfsh_back.sv =====
`default_nettype none

module rfsh_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           job_valid,
  input  wire rfsh_pkg::job_t job,
  output logic                pop,
  output logic                result_valid,
  input  wire logic           result_ready,
  output rfsh_pkg::out_t      result
);

  logic [2:0]     idx;
  logic [7:0]     sum;
  logic [2:0]     last_idx;
  logic [7:0]     count_byte;
  logic [7:0]     data_byte;
  logic [7:0]     frame_byte;
  logic           frame_end;
  logic           load;
  rfsh_pkg::out_t next_out;

  assign load = job_valid && (!result_valid || result_ready);

  // Frame length and count field by request kind.
  always_comb begin
    unique case (job.action)
      rfsh_pkg::ACT_WR1: begin
        last_idx   = rfsh_pkg::LAST_WR1;
        count_byte = rfsh_pkg::WR1_COUNT;
      end
      rfsh_pkg::ACT_WR2: begin
        last_idx   = rfsh_pkg::LAST_WR2;
        count_byte = rfsh_pkg::WR2_COUNT;
      end
      default: begin
        last_idx   = rfsh_pkg::LAST_RD;
        count_byte = rfsh_pkg::READ_COUNT;
      end
    endcase
  end

  // Frame byte at the current position; the checksum closes the frame.
  always_comb begin
    unique case (idx)
      rfsh_pkg::IDX_STX:   data_byte = rfsh_pkg::STX_BYTE;
      rfsh_pkg::IDX_CMD:   data_byte = (job.action == rfsh_pkg::ACT_RD) ?
                                       rfsh_pkg::CMD_READ : rfsh_pkg::CMD_WRITE;
      rfsh_pkg::IDX_ADDR:  data_byte = job.addr;
      rfsh_pkg::IDX_COUNT: data_byte = count_byte;
      rfsh_pkg::IDX_DLO:   data_byte = job.wval[7:0];
      rfsh_pkg::IDX_DHI:   data_byte = job.wval[15:8];
      default:             data_byte = 8'h00;
    endcase
    frame_end  = (idx == last_idx);
    frame_byte = frame_end ? sum : data_byte;
    pop        = load && (job.is_verdict || frame_end);

    if (job.is_verdict) begin
      next_out.out_kind    = 1'b1;
      next_out.tx_byte     = 8'h00;
      next_out.last_of_run = 1'b0;
      next_out.verdict     = job.verdict;
      next_out.read_value  = job.rv;
    end else begin
      next_out.out_kind    = 1'b0;
      next_out.tx_byte     = frame_byte;
      next_out.last_of_run = frame_end;
      next_out.verdict     = rfsh_pkg::VD_OK;
      next_out.read_value  = 8'h00;
    end
  end

  // Sequencer position and running checksum.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
      sum <= '0;
    end else if (load && !job.is_verdict) begin
      if (frame_end) begin
        idx <= '0;
        sum <= '0;
      end else begin
        idx <= idx + 3'd1;
        sum <= sum + frame_byte;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= next_out;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/register_frame_serial_host.sv =====
// Host side of a framed register-access serial link.
// The item channel (item_valid/item_ready/item) takes requests (write one
// byte, write two bytes, read one register) and received response bytes.
// The result channel (result_valid/result_ready/result) gives transmit frame
// bytes, ending in an additive checksum byte marked last_of_run, and one
// verdict for each response byte marked rx_last.
// An item is accepted in any cycle in which the two-entry job queue between
// the classifier and the frame sequencer has room. Non-final response bytes
// only update the receive checksum, count, overflow flag and third byte.
// The sequencer emits one result byte per cycle while the receiver takes
// them; a request frame has 6, 7 or 5 bytes (one-byte write, two-byte
// write, read) and a verdict is a single result.
// When the receiver stalls, the output register holds its result, the queue
// fills and item_ready falls. Reset clears the pending request, the receive
// state and the output valid flag, and empties the queue.
`default_nettype none

module register_frame_serial_host #(
  parameter int MAX_RESPONSE_BYTES = 64
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          item_valid,
  output logic               item_ready,
  input  wire rfsh_pkg::in_t item,
  output logic               result_valid,
  input  wire logic          result_ready,
  output rfsh_pkg::out_t     result
);

  logic           accept;
  logic           push;
  logic           pop;
  logic           q_full;
  logic           q_empty;
  rfsh_pkg::job_t push_job;
  rfsh_pkg::job_t head_job;

  assign item_ready = !q_full;
  assign accept     = item_valid && item_ready;

  rfsh_front #(
    .MAX_RESPONSE_BYTES(MAX_RESPONSE_BYTES)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (item),
    .push   (push),
    .job    (push_job)
  );

  rfsh_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  rfsh_back u_back (
    .clk          (clk),
    .rst          (rst),
    .job_valid    (!q_empty),
    .job          (head_job),
    .pop          (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

`default_nettype wire
